[rtl/aac_pkg.sv]
// Shared types, codes and reset constants of the alarm arming controller.
`default_nettype none
package aac_pkg;

    // Default counter register width in bits.
    localparam int TIME_WIDTH_DEF = 20;

    // Register reset values, cut to the register width where used.
    localparam logic [31:0] TRIG_MS_RESET = 32'd10000;
    localparam logic [31:0] FB_MS_RESET   = 32'd500;

    // Register indexes.
    localparam logic REG_TRIG_MS = 1'b0;
    localparam logic REG_FB_MS   = 1'b1;

    typedef enum logic [3:0] {
        ST_UNCONF    = 4'b0001,
        ST_UNLOCKED  = 4'b0010,
        ST_LOCKED    = 4'b0100,
        ST_TRIGGERED = 4'b1000
    } t_arm_state;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_SENSOR   = 3'd1,
        REQ_REMOTE   = 3'd2,
        REQ_EXTERNAL = 3'd3,
        REQ_CONFIGED = 3'd4,
        REQ_FEEDBACK = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_CHANGED = 2'd1,
        EV_FAILED  = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        STS_UNCONF    = 2'd0,
        STS_UNLOCKED  = 2'd1,
        STS_LOCKED    = 2'd2,
        STS_TRIGGERED = 2'd3
    } t_status;

    // ASCII characters of the external status request.
    localparam logic [7:0] CH_LOCK   = 8'h31;
    localparam logic [7:0] CH_UNLOCK = 8'h32;
    localparam logic [7:0] CH_TRIG   = 8'h33;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_NINE   = 8'h39;

    function automatic t_status state_code(input t_arm_state s);
        t_status c;
        unique case (s)
            ST_UNCONF:    c = STS_UNCONF;
            ST_UNLOCKED:  c = STS_UNLOCKED;
            ST_LOCKED:    c = STS_LOCKED;
            ST_TRIGGERED: c = STS_TRIGGERED;
            default:      c = STS_UNCONF;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/alarm_arming_controller_unit.sv]
// Alarm arming controller: state, elapsed counters, register port and result path.
`default_nettype none
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one request item: i_req_type
//   (tick, sensor edge, remote press, external status, configured, feedback)
//   and i_ext_code, the ASCII character of an external status request.
//   Output channel (o_out_valid / i_out_stall) returns one result item per
//   request: o_alarm_on, o_status and o_event_res.
//   Each item is worked combinationally: the state update and the alarm compare
//   sit between the input handshake and the output register, or the skid entry
//   when the output result is not taken; an item can enter every cycle unless stalled.
//   A one-entry skid register behind the output register holds a result while
//   the receiver stalls; o_in_stall rises only when the skid entry is full,
//   so one more item is taken after the output stalls.
//   The APB port holds trigger_alarm_ms (addr 0) and feedback_alarm_ms
//   (addr 4); pready is always high, write during idle only.
//   Synchronous reset: unconfigured, both counters expired (all ones),
//   no feedback seen, output and skid empty, registers to 10000 and 500.
module alarm_arming_controller_unit #(
    parameter int TIME_WIDTH = aac_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [7:0]            i_ext_code,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_alarm_on,
    output logic [1:0]                 o_status,
    output logic [1:0]                 o_event_res,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CW = TIME_WIDTH + 1;    // elapsed counters, one bit wider

    // configuration registers
    logic [TIME_WIDTH-1:0] r_trig_ms;
    logic [TIME_WIDTH-1:0] r_fb_ms;

    // block state
    aac_pkg::t_arm_state r_state, n_state;
    logic [CW-1:0]       r_since_trig, n_since_trig;
    logic [CW-1:0]       r_since_fb, n_since_fb;
    logic                r_fb_seen, n_fb_seen;

    // result path: output register and skid entry
    logic                r_out_valid;
    logic                r_out_alarm;
    aac_pkg::t_status    r_out_status;
    aac_pkg::t_event     r_out_event;
    logic                r_skd_valid;
    logic                r_skd_alarm;
    aac_pkg::t_status    r_skd_status;
    aac_pkg::t_event     r_skd_event;

    logic                in_accept;
    logic                out_take;
    logic                cfg_write;
    aac_pkg::t_event     n_event;
    logic                n_alarm;
    logic                do_move;
    aac_pkg::t_arm_state move_target;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_comb begin
        if (paddr[2] == aac_pkg::REG_FB_MS) begin
            prdata = 32'(r_fb_ms);
        end else begin
            prdata = 32'(r_trig_ms);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ms <= aac_pkg::TRIG_MS_RESET[TIME_WIDTH-1:0];
            r_fb_ms   <= aac_pkg::FB_MS_RESET[TIME_WIDTH-1:0];
        end else if (cfg_write) begin
            if (paddr[2] == aac_pkg::REG_TRIG_MS) begin
                r_trig_ms <= pwdata[TIME_WIDTH-1:0];
            end else begin
                r_fb_ms <= pwdata[TIME_WIDTH-1:0];
            end
        end
    end

    // ---------------- next state ----------------
    // First pick whether the request moves the state and where to; then the
    // move side effects (feedback beep on lock/unlock swaps, trigger timer
    // restart on entering triggered) are applied in one place.
    always_comb begin
        do_move     = 1'b0;
        move_target = r_state;
        n_event     = aac_pkg::EV_NONE;
        n_state     = r_state;
        n_since_trig = r_since_trig;
        n_since_fb   = r_since_fb;
        n_fb_seen    = r_fb_seen;

        case (i_req_type)
            aac_pkg::REQ_TICK: begin
                // saturate at all ones
                if (!(&r_since_trig)) n_since_trig = r_since_trig + CW'(1);
                if (!(&r_since_fb))   n_since_fb   = r_since_fb + CW'(1);
            end
            aac_pkg::REQ_SENSOR: begin
                if (r_state == aac_pkg::ST_LOCKED) begin
                    do_move     = 1'b1;
                    move_target = aac_pkg::ST_TRIGGERED;
                end
            end
            aac_pkg::REQ_REMOTE: begin
                if (r_state == aac_pkg::ST_UNLOCKED) begin
                    do_move     = 1'b1;
                    move_target = aac_pkg::ST_LOCKED;
                end else if (r_state != aac_pkg::ST_UNCONF) begin
                    do_move     = 1'b1;
                    move_target = aac_pkg::ST_UNLOCKED;
                end
            end
            aac_pkg::REQ_EXTERNAL: begin
                // one ASCII digit; a non-digit, '0' and '4' are ignored
                case (i_ext_code) inside
                    aac_pkg::CH_LOCK: begin
                        do_move     = 1'b1;
                        move_target = aac_pkg::ST_LOCKED;
                    end
                    aac_pkg::CH_UNLOCK: begin
                        do_move     = 1'b1;
                        move_target = aac_pkg::ST_UNLOCKED;
                    end
                    aac_pkg::CH_TRIG: begin
                        do_move     = 1'b1;
                        move_target = aac_pkg::ST_TRIGGERED;
                    end
                    [aac_pkg::CH_FIVE:aac_pkg::CH_NINE]: n_event = aac_pkg::EV_FAILED;
                    default: ;
                endcase
            end
            aac_pkg::REQ_CONFIGED: begin
                if (r_state == aac_pkg::ST_UNCONF) n_state = aac_pkg::ST_UNLOCKED;
            end
            aac_pkg::REQ_FEEDBACK: begin
                n_since_fb = '0;
                n_fb_seen  = 1'b1;
            end
            default: ;
        endcase

        if (do_move) begin
            n_event = aac_pkg::EV_CHANGED;
            n_state = move_target;
            if ((r_state == aac_pkg::ST_LOCKED && move_target == aac_pkg::ST_UNLOCKED) ||
                (r_state == aac_pkg::ST_UNLOCKED && move_target == aac_pkg::ST_LOCKED)) begin
                n_since_fb = '0;
                n_fb_seen  = 1'b1;
            end
            if (move_target == aac_pkg::ST_TRIGGERED) n_since_trig = '0;
        end

        // alarm drive after this item
        n_alarm = (n_state == aac_pkg::ST_TRIGGERED && n_since_trig <= CW'(r_trig_ms)) ||
                  (n_fb_seen && n_since_fb <= CW'(r_fb_ms));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aac_pkg::ST_UNCONF;
            r_since_trig <= '1;
            r_since_fb   <= '1;
            r_fb_seen    <= 1'b0;
        end else if (in_accept) begin
            r_state      <= n_state;
            r_since_trig <= n_since_trig;
            r_since_fb   <= n_since_fb;
            r_fb_seen    <= n_fb_seen;
        end
    end

    // ---------------- result path ----------------
    // Skid is only written when the output holds a result that is not taken;
    // input stalls while the skid is full, so no accept meets a full skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (in_accept && (!r_out_valid || out_take)) begin
                r_out_valid <= 1'b1;
            end else if (in_accept) begin
                r_skd_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= r_skd_valid;
                r_skd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (!r_out_valid || out_take)) begin
            r_out_alarm  <= n_alarm;
            r_out_status <= aac_pkg::state_code(n_state);
            r_out_event  <= n_event;
        end else if (in_accept) begin
            r_skd_alarm  <= n_alarm;
            r_skd_status <= aac_pkg::state_code(n_state);
            r_skd_event  <= n_event;
        end else if (out_take) begin
            r_out_alarm  <= r_skd_alarm;
            r_out_status <= r_skd_status;
            r_out_event  <= r_skd_event;
        end
    end

    assign o_in_stall  = r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_alarm_on  = r_out_alarm;
    assign o_status    = r_out_status;
    assign o_event_res = r_out_event;

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_lock_beep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_state == aac_pkg::ST_UNLOCKED && n_state == aac_pkg::ST_LOCKED)
        |=> (r_since_fb == '0 && r_fb_seen))
        else $error("locking did not start the feedback beep");

    a_trigger_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_state == aac_pkg::ST_TRIGGERED && r_state != aac_pkg::ST_TRIGGERED)
        |=> (r_since_trig == '0))
        else $error("entering triggered did not restart the trigger timer");

endmodule
`default_nettype wire

[bench/aac_checker.sv]
// Checker for the alarm arming controller: follows register writes, predicts every result item.
module aac_checker
    import aac_pkg::*;
#(
    parameter int TW = TIME_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_ext_code,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_alarm_on,
    input  wire logic [1:0]  i_status,
    input  wire logic [1:0]  i_event_res,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_fail_count,
    output int               o_due_count,
    output int               o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic    alarm_on;
        t_status status;
        t_event  ev;
    } t_alarm_result;

    // predicted block state and register copies
    t_status       arm;
    logic [TW:0]   since_trig;
    logic [TW:0]   since_fb;
    logic          fb_seen;
    logic [TW-1:0] trig_ms;
    logic [TW-1:0] fb_ms;

    t_alarm_result results_due[$];

    task automatic report_mismatch(input string msg);
        // keep the log short if the block is badly broken
        if (o_fail_count < 100) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    function automatic logic [TW:0] count_up(input logic [TW:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic start_beep();
        since_fb = '0;
        fb_seen  = 1'b1;
    endtask

    task automatic enter_state(input t_status next, output t_event ev);
        // lock/unlock flips sound the feedback beep
        if ((arm == STS_LOCKED && next == STS_UNLOCKED) ||
            (arm == STS_UNLOCKED && next == STS_LOCKED)) begin
            start_beep();
        end
        if (next == STS_TRIGGERED) begin
            since_trig = '0;
        end
        arm = next;
        ev  = EV_CHANGED;
    endtask

    task automatic step_alarm(input logic [2:0] req, input logic [7:0] code,
                              output t_alarm_result r);
        t_event ev;
        ev = EV_NONE;
        case (req)
            REQ_TICK: begin
                since_trig = count_up(since_trig);
                since_fb   = count_up(since_fb);
            end
            REQ_SENSOR: begin
                if (arm == STS_LOCKED) enter_state(STS_TRIGGERED, ev);
            end
            REQ_REMOTE: begin
                if (arm == STS_UNLOCKED) enter_state(STS_LOCKED, ev);
                else if (arm != STS_UNCONF) enter_state(STS_UNLOCKED, ev);
            end
            REQ_EXTERNAL: begin
                // '0', '4' and non-digits fall through with no event
                if (code == CH_LOCK) enter_state(STS_LOCKED, ev);
                else if (code == CH_UNLOCK) enter_state(STS_UNLOCKED, ev);
                else if (code == CH_TRIG) enter_state(STS_TRIGGERED, ev);
                else if (code >= CH_FIVE && code <= CH_NINE) ev = EV_FAILED;
            end
            REQ_CONFIGED: begin
                if (arm == STS_UNCONF) arm = STS_UNLOCKED;
            end
            REQ_FEEDBACK: begin
                start_beep();
            end
            default: ;
        endcase
        r.alarm_on = (arm == STS_TRIGGERED && since_trig <= {1'b0, trig_ms}) ||
                     (fb_seen && since_fb <= {1'b0, fb_ms});
        r.status   = arm;
        r.ev       = ev;
    endtask

    always @(posedge i_clk) begin : watch
        t_alarm_result got;
        t_alarm_result want;
        if (!i_rst_n) begin
            arm        = STS_UNCONF;
            since_trig = '1;
            since_fb   = '1;
            fb_seen    = 1'b0;
            trig_ms    = TRIG_MS_RESET[TW-1:0];
            fb_ms      = FB_MS_RESET[TW-1:0];
            results_due.delete();
            o_fail_count   = 0;
            o_result_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                got.alarm_on = i_alarm_on;
                got.status   = t_status'(i_status);
                got.ev       = t_event'(i_event_res);
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              o_result_count));
                end else begin
                    want = results_due.pop_front();
                    if (got.alarm_on !== want.alarm_on)
                        report_mismatch($sformatf("result %0d: alarm_on %0b, expected %0b",
                                                  o_result_count, got.alarm_on, want.alarm_on));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                                  o_result_count, got.status, want.status));
                    if (got.ev !== want.ev)
                        report_mismatch($sformatf("result %0d: event %0d, expected %0d",
                                                  o_result_count, got.ev, want.ev));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_alarm(i_req_type, i_ext_code, want);
                results_due.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00) begin
                case (i_paddr[2])
                    REG_TRIG_MS: trig_ms = i_pwdata[TW-1:0];
                    REG_FB_MS:   fb_ms   = i_pwdata[TW-1:0];
                    default: ;
                endcase
            end
        end
        o_due_count = results_due.size();
    end

endmodule

[bench/tb_top.sv]
// Top of the alarm arming controller bench: clock, reset, stimulus, register writes and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aac_pkg::*;

    // ASCII '0', '4' and '7', and the two request codes the block leaves unused
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    // byte addresses of the two registers
    localparam logic [2:0] ADDR_TRIG_MS = {REG_TRIG_MS, 2'b00};
    localparam logic [2:0] ADDR_FB_MS   = {REG_FB_MS, 2'b00};

    // receiver hold-off long enough to fill output and skid and back up the input
    localparam int HOLD_CYCLES = 40;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_req_type  = '0;
    logic [7:0]  i_ext_code  = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    wire logic        o_in_stall;
    wire logic        o_out_valid;
    wire logic        o_alarm_on;
    wire logic [1:0]  o_status;
    wire logic [1:0]  o_event_res;
    wire logic [31:0] prdata;
    wire logic        pready;

    int fail_count;
    int due_count;
    int result_count;
    int sent_count     = 0;
    int settings_count = 1;   // reset values count as the first setting

    // quiet: neither side idles; hold_wanted: receiver starts one long hold-off
    bit quiet       = 1'b0;
    bit hold_wanted = 1'b0;

    always #10 i_clk = ~i_clk;

    alarm_arming_controller_unit uut (.*);

    aac_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_ext_code    (i_ext_code),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_alarm_on    (o_alarm_on),
        .i_status      (o_status),
        .i_event_res   (o_event_res),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count),
        .o_result_count(result_count)
    );

    // Offer one item. Random gaps drop valid between items; once valid is up
    // the payload holds until the block takes it. Called and returns at a
    // rising edge, so valid gets a single update per edge.
    task automatic offer_request(input logic [2:0] req, input logic [7:0] code);
        while (!quiet && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_ext_code <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    // Random mix weighted toward ticks and state changes; external requests
    // mostly carry a digit, the rest any byte.
    task automatic offer_random(input int count);
        int          pick;
        logic [2:0]  req;
        logic [7:0]  code;
        repeat (count) begin
            pick = $urandom_range(99);
            code = 8'($urandom_range(255));
            if (pick < 38) begin
                req = REQ_TICK;
            end else if (pick < 50) begin
                req = REQ_SENSOR;
            end else if (pick < 64) begin
                req = REQ_REMOTE;
            end else if (pick < 82) begin
                req = REQ_EXTERNAL;
                if ($urandom_range(3) != 0) code = CH_ZERO + 8'($urandom_range(9));
            end else if (pick < 86) begin
                req = REQ_CONFIGED;
            end else if (pick < 95) begin
                req = REQ_FEEDBACK;
            end else begin
                req = ($urandom_range(1) != 0) ? REQ_SPARE7 : REQ_SPARE6;
            end
            offer_request(req, code);
        end
    endtask

    // APB write: setup phase, access phase, then the bus is released.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every predicted result, then wait out a margin
    // so the block is quiet before a register write or the verdict.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (due_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic new_setting(input logic [31:0] trig, input logic [31:0] fb);
        settle();
        write_reg(ADDR_TRIG_MS, trig);
        write_reg(ADDR_FB_MS, fb);
        settings_count++;
    endtask

    // Receiver: random stalls, none while quiet, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= !quiet && $urandom_range(99) < 32;
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: unconfigured state ---
        offer_request(REQ_TICK, '0);              // counters already expired, must hold
        offer_request(REQ_SENSOR, '0);            // sensor ignored unless locked
        offer_request(REQ_REMOTE, '0);            // remote does nothing unconfigured
        offer_request(REQ_EXTERNAL, CH_ZERO);     // '0' ignored
        offer_request(REQ_EXTERNAL, CH_FOUR);     // '4' ignored
        offer_request(REQ_EXTERNAL, CH_SEVEN);    // failed attempt
        offer_request(REQ_EXTERNAL, 8'h2F);       // just below '0': not a digit
        offer_request(REQ_EXTERNAL, 8'h3A);       // just above '9': not a digit
        offer_request(REQ_EXTERNAL, 8'hFF);
        offer_request(REQ_EXTERNAL, 8'h00);
        offer_request(REQ_SPARE6, 8'hFF);         // unused request codes
        offer_request(REQ_SPARE7, 8'hFF);
        offer_request(REQ_FEEDBACK, '0);          // beep starts with no prior feedback

        // Leaving unconfigured: either the configured notice or an external
        // request, picked by the seed since there is only one way out per run.
        if ($urandom_range(1) != 0) begin
            offer_request(REQ_CONFIGED, '0);
        end else begin
            case ($urandom_range(2))
                0:       offer_request(REQ_EXTERNAL, CH_LOCK);
                1:       offer_request(REQ_EXTERNAL, CH_UNLOCK);
                default: offer_request(REQ_EXTERNAL, CH_TRIG);
            endcase
        end

        // --- directed: configured states ---
        offer_request(REQ_CONFIGED, '0);          // no effect once configured
        offer_request(REQ_EXTERNAL, CH_UNLOCK);   // reach a known state
        offer_request(REQ_REMOTE, '0);            // unlocked -> locked
        offer_request(REQ_SENSOR, '0);            // locked -> triggered
        offer_request(REQ_SENSOR, '0);            // already triggered
        offer_request(REQ_REMOTE, '0);            // triggered -> unlocked
        offer_request(REQ_EXTERNAL, CH_LOCK);
        offer_request(REQ_EXTERNAL, CH_LOCK);     // same state still reports a change
        offer_request(REQ_EXTERNAL, CH_TRIG);
        offer_request(REQ_EXTERNAL, CH_UNLOCK);   // triggered -> unlocked, no beep
        offer_request(REQ_EXTERNAL, CH_NINE);
        offer_request(REQ_EXTERNAL, CH_FIVE);

        // --- random phases over several register settings ---
        offer_random(100);

        // short windows so the alarm and beep expire under ticks;
        // the long output hold-off runs here with the sender flat out
        new_setting(32'd5, 32'd3);
        quiet       = 1'b1;
        hold_wanted = 1'b1;
        offer_random(60);
        quiet = 1'b0;
        offer_random(90);

        // zero windows: alarm only until the next tick after the event
        new_setting(32'd0, 32'd0);
        offer_random(100);

        // all ones on the bus: only the low register bits stick
        new_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_random(100);

        // small random windows, with a long run where neither side idles
        new_setting(32'($urandom_range(40)), 32'($urandom_range(40)));
        quiet = 1'b1;
        offer_random(100);
        quiet = 1'b0;
        offer_random(50);

        // arbitrary bus words
        new_setting($urandom(), $urandom());
        offer_random(100);

        settle();
        $display("Sent %0d requests and checked %0d results over %0d register settings,",
                 sent_count, result_count, settings_count);
        $display("including one %0d-cycle output hold-off.", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d results still expected", due_count);
        $display("Mismatches found");
        $finish;
    end

endmodule
